// ----- src/dmm_pkg.sv -----
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared widths, register indexes, mode codes and the command and status
// structs that join the decimator controller and datapath.
// ----------------------------------------------------------------------------
package dmm_pkg;

  // Configuration register widths and port widths
  localparam int FACT_W     = 11;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FACTOR = 2'd0,
    REG_MODE   = 2'd1
  } cfg_reg_e;

  // Reduction mode codes; any other code picks the first sample of a block
  localparam logic [MODE_W-1:0] MODE_MEAN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX  = 2'd1;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_LOAD = 3'b100
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // take the presented sample into the block
    logic div_step;  // one quotient bit of the mean
    logic load_out;  // move the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic has_result;  // the presented sample would produce a result
    logic need_div;    // that result is a block mean
    logic out_free;    // output register can take a new result
  } dp_sts_t;

endpackage

// ----- src/dmm_if.sv -----
// ----------------------------------------------------------------------------
// dmm_if
// Valid/ready channels for incoming samples and outgoing reduced values.
// ----------------------------------------------------------------------------
interface dmm_sample_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface dmm_result_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] reduced_value;

  modport source (output valid, output reduced_value, input ready);
  modport sink   (input valid, input reduced_value, output ready);
endinterface

// ----- src/dmm_ctrl.sv -----
// ----------------------------------------------------------------------------
// dmm_ctrl
// Sequencer for the decimator: takes samples, runs the serial divider for
// block means and hands results to the output register.
// ----------------------------------------------------------------------------
module dmm_ctrl #(
  parameter int SUM_W = 27
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dmm_pkg::dp_sts_t sts_i,
  output dmm_pkg::dp_cmd_t cmd_o
);
  import dmm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                last_step;

  assign last_step = (step_q == STEP_W'(SUM_W - 1));

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.has_result) begin
          step_d  = '0;
          state_d = sts_i.need_div ? S_DIV : S_LOAD;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (last_step) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // A mean-producing transfer starts the divider from its first step
  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && cmd_o.accept && sts_i.has_result && sts_i.need_div)
    |=> (state_q == S_DIV && step_q == '0))
    else $error("divider not started cleanly");

  // The divider advances one step a cycle until it hands over to the load
  a_div_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV)
    |=> ((state_q == S_DIV && step_q == $past(step_q) + 1'b1) || state_q == S_LOAD))
    else $error("divider step sequence broken");

endmodule

// ----- src/dmm_dp.sv -----
// ----------------------------------------------------------------------------
// dmm_dp
// Datapath of the decimator: configuration registers, block accumulator,
// running maximum or first sample, serial restoring divider for the mean
// and the output register.
// ----------------------------------------------------------------------------
module dmm_dp #(
  parameter int MAX_FACTOR   = 1024,
  parameter int SAMPLE_WIDTH = 16,
  parameter int SUM_W        = 27
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dmm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dmm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_i,
  input  dmm_pkg::dp_cmd_t                 cmd_i,
  output dmm_pkg::dp_sts_t                 sts_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]   out_value_o
);
  import dmm_pkg::*;

  // Configuration
  logic [FACT_W-1:0]              factor_q;
  logic [MODE_W-1:0]              mode_q;
  // Open block
  logic signed [SUM_W-1:0]        sum_q;
  logic [FACT_W-1:0]              count_q;
  logic signed [SAMPLE_WIDTH-1:0] held_q;
  // Pending result and divider
  logic signed [SAMPLE_WIDTH-1:0] res_q;
  logic                           sel_div_q;
  logic                           neg_q;
  logic [SUM_W-1:0]               quo_q;
  logic [FACT_W-1:0]              rem_q;
  // Output register
  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_q;

  logic [FACT_W-1:0]              eff_factor;
  logic                           pass;
  logic [FACT_W-1:0]              count_inc;
  logic                           complete;
  logic signed [SUM_W-1:0]        sum_new;
  logic [SUM_W-1:0]               sum_mag;
  logic signed [SAMPLE_WIDTH-1:0] held_new;
  logic [FACT_W:0]                trial;
  logic                           trial_ge;
  logic [FACT_W:0]                trial_sub;
  logic [SUM_W-1:0]               quo_signed;
  logic                           cfg_hit;

  // Clamp the factor to the largest block size
  assign eff_factor = (32'(factor_q) > MAX_FACTOR) ? FACT_W'(MAX_FACTOR) : factor_q;
  assign pass       = (eff_factor <= FACT_W'(1));
  assign count_inc  = count_q + 1'b1;
  assign complete   = (count_inc >= eff_factor);
  assign sum_new    = sum_q + SUM_W'(sample_i);
  assign sum_mag    = sum_new[SUM_W-1] ? (~sum_new + 1'b1) : sum_new;

  // Running maximum, or first sample of the block
  always_comb begin
    held_new = held_q;
    if (count_q == '0) begin
      held_new = sample_i;
    end else if (mode_q == MODE_MAX && sample_i > held_q) begin
      held_new = sample_i;
    end
  end

  // One restoring division step on the magnitude of the block sum
  assign trial      = {rem_q, quo_q[SUM_W-1]};
  assign trial_ge   = (trial >= {1'b0, eff_factor});
  assign trial_sub  = trial - {1'b0, eff_factor};
  assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == REG_FACTOR || cfg_idx_i == REG_MODE);

  assign sts_o.has_result = pass || complete;
  assign sts_o.need_div   = !pass && complete && (mode_q == MODE_MEAN);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_q;

  // Configuration and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACT_W'(1);
      mode_q   <= MODE_MEAN;
      sum_q    <= '0;
      count_q  <= '0;
      held_q   <= '0;
    end else if (cfg_hit) begin
      // Any register write discards the open block
      if (cfg_idx_i == REG_FACTOR) begin
        factor_q <= cfg_data_i[FACT_W-1:0];
      end else begin
        mode_q <= cfg_data_i[MODE_W-1:0];
      end
      sum_q   <= '0;
      count_q <= '0;
      held_q  <= '0;
    end else if (cmd_i.accept && !pass) begin
      if (complete) begin
        sum_q   <= '0;
        count_q <= '0;
        held_q  <= '0;
      end else begin
        sum_q   <= sum_new;
        count_q <= count_inc;
        held_q  <= held_new;
      end
    end
  end

  // Pending result and divider; payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (pass) begin
        res_q     <= sample_i;
        sel_div_q <= 1'b0;
      end else begin
        res_q     <= held_new;
        sel_div_q <= (mode_q == MODE_MEAN);
        neg_q     <= sum_new[SUM_W-1];
        quo_q     <= sum_mag;
        rem_q     <= '0;
      end
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], trial_ge};
      rem_q <= trial_ge ? trial_sub[FACT_W-1:0] : trial[FACT_W-1:0];
    end
  end

  // Output register: hold until transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= sel_div_q ? quo_signed[SAMPLE_WIDTH-1:0] : res_q;
    end
  end

  // The open block never reaches the block size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eff_factor <= FACT_W'(1)) || (count_q < eff_factor))
    else $error("block count reached block size");

  // The partial remainder stays below the divisor while dividing
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < eff_factor))
    else $error("divider remainder out of range");

  // A new result is only loaded when the output register is free
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("pending result overwritten");

endmodule

// ----- src/block_decimator_mean_max_pick_core.sv -----
// Sequence: pass-through, maximum and first-sample results go from the completing
//   transfer through the load state into the output register; a block mean first
//   passes through the divide state, run by the one-bit-a-cycle divider.
// Flow: samples are taken only while the sequencer is idle; a sample that produces a
//   result holds off new samples until loaded, longer while the output register is full.
// Reset: factor 1, mode mean, open block cleared, output register empty.
// ----------------------------------------------------------------------------
// block_decimator_mean_max_pick_core
// Block decimator: groups samples into blocks of a configured size and emits
// the mean, the maximum or the first sample of each block.
// ----------------------------------------------------------------------------
module block_decimator_mean_max_pick_core #(
  parameter int MAX_FACTOR   = 1024,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dmm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dmm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  dmm_sample_if.sink                     in_i,
  dmm_result_if.source                   out_o
);
  import dmm_pkg::*;

  localparam int SUM_W = SAMPLE_WIDTH + FACT_W;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  dmm_ctrl #(
    .SUM_W (SUM_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  dmm_dp #(
    .MAX_FACTOR   (MAX_FACTOR),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_W        (SUM_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (in_i.sample),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_value_o (out_o.reduced_value)
  );

endmodule

// ----- verif/dmm_reduced_value_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dmm_reduced_value_checker
// Watches the configuration port and both channels of the block decimator,
// forecasts each reduced value from the accepted samples and the register
// settings, and compares every output transfer with the oldest forecast.
// ----------------------------------------------------------------------------
module dmm_reduced_value_checker #(
  parameter int MAX_FACTOR = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dmm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dmm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  dmm_sample_if                          smp_i,
  dmm_result_if                          red_i,
  output int                             mismatches_o,
  output int                             pending_o,
  output int                             checked_o
);
  import dmm_pkg::*;

  // Shadow copy of the registers and the open block
  logic [FACT_W-1:0]  factor_q;
  logic [MODE_W-1:0]  mode_q;
  logic signed [25:0] sum_q;
  int                 count_q;
  logic signed [15:0] held_q;

  // Reduced values still owed by the block, oldest first
  logic signed [15:0] expected_values[$];

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches_o++;
  endtask

  task automatic clear_block();
    sum_q   = '0;
    count_q = 0;
    held_q  = '0;
  endtask

  // Fold one sample into the open block; queue a value when the block closes
  task automatic decimate_sample(input logic signed [15:0] s);
    int     eff;
    longint quotient;
    eff = (factor_q > MAX_FACTOR) ? MAX_FACTOR : int'(factor_q);
    if (eff <= 1) begin
      expected_values.push_back(s);
      return;
    end
    if (count_q == 0) begin
      held_q = s;
    end else if (mode_q == MODE_MAX && s > held_q) begin
      held_q = s;
    end
    sum_q += s;
    count_q++;
    if (count_q == eff) begin
      // mean truncates toward zero; every other mode hands back the held value
      if (mode_q == MODE_MEAN) begin
        quotient = longint'(sum_q) / longint'(eff);
      end else begin
        quotient = longint'(held_q);
      end
      expected_values.push_back(quotient[15:0]);
      clear_block();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [15:0] want;
    if (!rst_ni) begin
      factor_q     = FACT_W'(1);
      mode_q       = MODE_MEAN;
      mismatches_o = 0;
      checked_o    = 0;
      clear_block();
      expected_values.delete();
    end else begin
      // Apply register writes; unknown indexes leave everything alone
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FACTOR: begin
            factor_q = cfg_data_i[FACT_W-1:0];
            clear_block();
          end
          REG_MODE: begin
            mode_q = cfg_data_i[MODE_W-1:0];
            clear_block();
          end
          default: ;
        endcase
      end
      // Compare an output transfer with the oldest forecast
      if (red_i.valid && red_i.ready) begin
        checked_o++;
        if (expected_values.size() == 0) begin
          flag_mismatch($sformatf("unexpected reduced value %0d", red_i.reduced_value));
        end else begin
          want = expected_values.pop_front();
          if (red_i.reduced_value !== want) begin
            flag_mismatch($sformatf("reduced_value got %0d, want %0d",
                                    red_i.reduced_value, want));
          end
        end
      end
      // Forecast from an input transfer
      if (smp_i.valid && smp_i.ready) begin
        decimate_sample(smp_i.sample);
      end
    end
    pending_o = expected_values.size();
  end

endmodule

// ----- verif/block_decimator_mean_max_pick_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_decimator_mean_max_pick_core_test
// Drives samples and register settings into the block decimator, with random
// gaps on the input and random back-pressure on the output; a side checker
// forecasts and compares every reduced value.
// ----------------------------------------------------------------------------
module block_decimator_mean_max_pick_core_test;
  import dmm_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_ITEMS  = 820;

  // Indexes with no register behind them, and the first-sample mode codes
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_FIRST     = 2'd2;
  localparam logic [MODE_W-1:0]    MODE_FIRST_ALT = 2'd3;

  localparam logic signed [15:0] S_MIN = 16'sh8000;
  localparam logic signed [15:0] S_MAX = 16'sh7FFF;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int mismatches, pending, checked;
  int items_sent, settings_run, cycles;
  bit steady;

  dmm_sample_if #(.W(16)) smp_bus ();
  dmm_result_if #(.W(16)) red_bus ();

  block_decimator_mean_max_pick_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (smp_bus.sink),
    .out_o      (red_bus.source)
  );

  dmm_reduced_value_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .smp_i        (smp_bus),
    .red_i        (red_bus),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #6 clk_i = ~clk_i;

  // Stall the output at random, except during the steady stretch
  always @(posedge clk_i) begin
    red_bus.ready <= steady || ($urandom_range(0, 99) >= 34);
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d values outstanding", pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one sample, idling first at random, and hold it until the transfer
  task automatic push_sample(input logic signed [15:0] s);
    if (!steady && $urandom_range(0, 99) < 34) begin
      smp_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 34);
    end
    smp_bus.valid  <= 1'b1;
    smp_bus.sample <= s;
    do @(posedge clk_i); while (!smp_bus.ready);
    items_sent++;
  endtask

  // Write a register once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    smp_bus.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] factor,
                           input logic [MODE_W-1:0] mode);
    write_reg(REG_FACTOR, factor);
    // random upper bits must be masked off by the mode register
    write_reg(REG_MODE, {(CFG_DATA_W-MODE_W)'($urandom_range(0, 511)), mode});
    settings_run++;
  endtask

  // Mostly uniform samples, with the extremes and zero crossings thrown in
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 19))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return 16'sh0000;
      3:       return -16'sh0001;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int fac, n, pick, first_item;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    smp_bus.valid  = 1'b0;
    smp_bus.sample = '0;
    items_sent    = 0;
    settings_run  = 0;
    steady        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pass-through straight out of reset, then with a factor of zero
    push_sample(S_MAX);
    push_sample(S_MIN);
    push_sample(16'sh0000);
    push_sample(-16'sh0001);
    configure(11'd0, MODE_MEAN);
    push_sample(16'sh5555);
    push_sample(-16'sh5556);

    // Mean at both extremes and truncation of a negative odd sum
    configure(11'd2, MODE_MEAN);
    push_sample(S_MIN);
    push_sample(S_MIN);
    push_sample(S_MAX);
    push_sample(S_MAX);
    push_sample(-16'sh0003);
    push_sample(16'sh0000);

    // Maximum, then first sample in both first-sample codes
    configure(11'd3, MODE_MAX);
    push_sample(-16'sh0005);
    push_sample(16'sh0007);
    push_sample(16'sh0002);
    configure(11'd2, MODE_FIRST);
    push_sample(16'sh0009);
    push_sample(-16'sh0004);
    configure(11'd2, MODE_FIRST_ALT);
    push_sample(-16'sh0007);
    push_sample(16'sh0064);

    // A write to a spare index keeps the open block
    configure(11'd3, MODE_MEAN);
    push_sample(16'sh0100);
    push_sample(-16'sh0031);
    write_reg(REG_SPARE_A, 11'h7FF);
    push_sample(16'sh0011);

    // A register write drops a half-filled block
    push_sample(16'sh7000);
    write_reg(REG_FACTOR, 11'd2);
    write_reg(REG_SPARE_B, 11'h2AA);
    push_sample(-16'sh0010);
    push_sample(16'sh0003);

    // Random settings, mostly small factors, some blocks left unfinished
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      steady = (settings_run >= 12 && settings_run < 20);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        fac = $urandom_range(0, 1);
      end else if (pick < 82) begin
        fac = $urandom_range(2, 8);
      end else begin
        fac = $urandom_range(9, 64);
      end
      configure(CFG_DATA_W'(fac), MODE_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 9) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  CFG_DATA_W'($urandom_range(0, 2047)));
      end
      if (fac <= 1) begin
        n = $urandom_range(4, 24);
      end else begin
        n = fac * $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, fac - 1);
      end
      repeat (n) push_sample(pick_sample());
    end
    steady = 1'b0;

    // Drain and let any stray output show itself
    smp_bus.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d samples across %0d register settings; %0d reduced values checked",
             items_sent, settings_run, checked);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
